// File: hw/rtl/cfq_pkg.sv
// Package for the circular FIFO queue: sizes, opcode, status and FSM state
// types, plus capacity clamp and ring index step helpers.
// No dependencies.
`default_nettype none

package cfq_pkg;

	localparam int DEPTH       = 16;
	localparam int DATA_W      = 32;
	localparam int TOT_W       = 32;
	localparam int CAP_W       = 5;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
	localparam int OUT_BITS    = DATA_W + CNT_W + 2 * TOT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OP_W        = 2;
	localparam int STAT_W      = 2;
	localparam int OUT_TUSER_W = STAT_W + 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_POP   = 2'd1,
		OP_PEEK  = 2'd2,
		OP_PURGE = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_PEEK,
		S_PURGE
	} fsm_state_t;

	// register value 0 acts as 1, anything above the storage depth as the depth
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		logic [CNT_W-1:0] r;
		if (cap == '0)
			r = CNT_W'(1);
		else if (int'(cap) > DEPTH)
			r = CNT_W'(DEPTH);
		else
			r = CNT_W'(cap);
		return r;
	endfunction

	// one slot forward, wrapping to zero at or past the capacity in use
	function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W:0]   nxt;
		logic [IDX_W-1:0] r;
		nxt = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
		if (nxt >= (CNT_W+1)'(cap))
			r = '0;
		else
			r = nxt[IDX_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/circular_fifo_queue.sv
// Circular FIFO queue top level: ring storage in a synchronous RAM, pointer
// and total registers, request FSM and the registered result stage.
// Depends on cfq_pkg.
//
// Channel   Dir  Handshake                    Content
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata item_data
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser status/valid, tdata data,
//                                             count, totals; tlast = last
// cfg       in   cfg_we                       capacity_in_use
//
// Put, and any failed or empty-queue request: the result register is loaded in the accepting cycle.
// Pop: the entry RAM read is registered, and the result is loaded from it in S_POP.
// Peek of N entries: one RAM read per entry, each result loaded in S_PEEK.
// Purge: the accepting cycle and then a zeroing sweep of the entry RAM one slot per
// cycle; the result is loaded at the last slot once the result register is free.
// A request is taken only while the FSM is idle and the result register is
// free or being emptied; a stalled result holds and blocks further requests.
// Reset clears pointers, count and totals; RAM contents are kept.
`default_nettype none

module circular_fifo_queue
	import cfq_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // item_data
	input  wire logic [OP_W-1:0]        s_axis_tuser,  // opcode
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // out_data, out_count, total_put,
	                                                   // total_popped, zero pad
	output logic [OUT_TUSER_W-1:0]      m_axis_tuser,  // status, data_valid
	output logic                        m_axis_tlast,
	input  wire logic                   cfg_we,
	input  wire logic [CAP_W-1:0]       cfg_wdata
);

	fsm_state_t state_q, state_d;

	logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [TOT_W-1:0] put_tot_q, put_tot_d, pop_tot_q, pop_tot_d;
	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] walk_q, walk_d, sweep_q, sweep_d;
	logic [CNT_W-1:0] remain_q, remain_d;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_s1;
	logic              re, we;
	logic [IDX_W-1:0]  raddr, waddr;
	logic [DATA_W-1:0] wdata;

	logic              out_valid_q, out_dvalid_q, out_last_q;
	status_t           out_status_q;
	logic [DATA_W-1:0] out_data_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [TOT_W-1:0]  out_tput_q, out_tpop_q;

	logic              ld, ld_dvalid, ld_last;
	status_t           ld_status;
	logic [DATA_W-1:0] ld_data;

	logic             in_acc, out_free, full, empty;
	logic [CNT_W-1:0] cap_eff;
	op_t              op;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cap_eff  = eff_cap(cap_q);
	assign full     = count_q >= cap_eff;
	assign empty    = count_q == '0;
	assign op       = op_t'(s_axis_tuser);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (op)
						OP_PUT:   state_d = S_IDLE;
						OP_POP:   state_d = empty ? S_IDLE : S_POP;
						OP_PEEK:  state_d = empty ? S_IDLE : S_PEEK;
						OP_PURGE: state_d = S_PURGE;
					endcase
				end
			end
			S_POP: begin
				if (out_free)
					state_d = S_IDLE;
			end
			S_PEEK: begin
				if (out_free && remain_q == CNT_W'(1))
					state_d = S_IDLE;
			end
			S_PURGE: begin
				if (sweep_q == IDX_W'(DEPTH - 1) && out_free)
					state_d = S_IDLE;
			end
		endcase
	end

	// datapath control
	always_comb begin
		s_axis_tready = (state_q == S_IDLE) && out_free;
		re        = 1'b0;
		raddr     = head_q;
		we        = 1'b0;
		waddr     = tail_q;
		wdata     = s_axis_tdata[DATA_W-1:0];
		ld        = 1'b0;
		ld_status = STAT_OK;
		ld_data   = '0;
		ld_dvalid = 1'b0;
		ld_last   = 1'b1;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		put_tot_d = put_tot_q;
		pop_tot_d = pop_tot_q;
		walk_d    = walk_q;
		remain_d  = remain_q;
		sweep_d   = sweep_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (op)
						OP_PUT: begin
							ld = 1'b1;
							if (full) begin
								ld_status = STAT_FULL;
							end else begin
								we        = 1'b1;
								tail_d    = step_idx(tail_q, cap_eff);
								count_d   = count_q + CNT_W'(1);
								put_tot_d = put_tot_q + TOT_W'(1);
							end
						end
						OP_POP: begin
							if (empty) begin
								ld        = 1'b1;
								ld_status = STAT_EMPTY;
							end else begin
								// read-first RAM: old entry comes back, slot is zeroed
								re        = 1'b1;
								we        = 1'b1;
								waddr     = head_q;
								wdata     = '0;
								count_d   = count_q - CNT_W'(1);
								pop_tot_d = pop_tot_q + TOT_W'(1);
								if (count_q == CNT_W'(1)) begin
									head_d = '0;
									tail_d = '0;
								end else begin
									head_d = step_idx(head_q, cap_eff);
								end
							end
						end
						OP_PEEK: begin
							if (empty) begin
								ld = 1'b1;
							end else begin
								re       = 1'b1;
								walk_d   = step_idx(head_q, cap_eff);
								remain_d = count_q;
							end
						end
						OP_PURGE: begin
							head_d  = '0;
							tail_d  = '0;
							count_d = '0;
							sweep_d = '0;
						end
					endcase
				end
			end
			S_POP: begin
				if (out_free) begin
					ld        = 1'b1;
					ld_data   = rdata_s1;
					ld_dvalid = 1'b1;
				end
			end
			S_PEEK: begin
				if (out_free) begin
					ld        = 1'b1;
					ld_data   = rdata_s1;
					ld_dvalid = 1'b1;
					ld_last   = remain_q == CNT_W'(1);
					if (remain_q != CNT_W'(1)) begin
						re       = 1'b1;
						raddr    = walk_q;
						walk_d   = step_idx(walk_q, cap_eff);
						remain_d = remain_q - CNT_W'(1);
					end
				end
			end
			S_PURGE: begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = '0;
				if (sweep_q != IDX_W'(DEPTH - 1))
					sweep_d = sweep_q + IDX_W'(1);
				else if (out_free)
					ld = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			put_tot_q <= '0;
			pop_tot_q <= '0;
			cap_q     <= CAP_RESET;
			walk_q    <= '0;
			remain_q  <= '0;
			sweep_q   <= '0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			put_tot_q <= put_tot_d;
			pop_tot_q <= pop_tot_d;
			walk_q    <= walk_d;
			remain_q  <= remain_d;
			sweep_q   <= sweep_d;
			if (cfg_we)
				cap_q <= cfg_wdata;
		end
	end

	// entry RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_s1 <= mem[raddr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ld)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_status_q <= ld_status;
			out_data_q   <= ld_data;
			out_dvalid_q <= ld_dvalid;
			out_last_q   <= ld_last;
			out_count_q  <= count_d;
			out_tput_q   <= put_tot_d;
			out_tpop_q   <= pop_tot_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_tpop_q, out_tput_q, out_count_q, out_data_q});
	assign m_axis_tuser  = {out_dvalid_q, out_status_q};
	assign m_axis_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH)
		else $error("entry count above storage depth");

	a_drained_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> head_q == '0 && tail_q == '0)
		else $error("empty queue with non-zero ring pointers");

	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> out_free)
		else $error("request taken while result register is blocked");

	a_peek_remain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PEEK |-> remain_q != '0)
		else $error("peek walk with nothing left to emit");

	a_fail_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != STAT_OK |-> !out_dvalid_q && out_last_q)
		else $error("failed request result carries data or misses last");

endmodule

`default_nettype wire
